// ===== hw/rtl/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
// No dependencies; used by lr_start, lr_stepper and line_rasterizer_unit.
package lr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS_DEF = 16;
  localparam int ORIGIN_X_RST   = 100;
  localparam int ORIGIN_Y_RST   = 160;

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_ORIGIN_X = 1'b0,
    CFG_ORIGIN_Y = 1'b1
  } cfg_idx_e;

  // Unit step directions, each -1, 0 or +1.
  typedef struct packed {
    logic signed [1:0] par_x;
    logic signed [1:0] par_y;
    logic signed [1:0] diag_x;
    logic signed [1:0] diag_y;
  } steps_t;

endpackage

// ===== hw/rtl/lr_start.sv =====
// Line setup: fast/slow axis, lengths, step directions and initial error.
// Depends on lr_pkg (steps_t).
module lr_start #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic        [COORD_BITS-1:0] fast_len_o,
  output logic        [COORD_BITS-1:0] slow_len_o,
  output logic signed [COORD_BITS:0]   err_init_o,
  output lr_pkg::steps_t               steps_o
);

  logic signed [COORD_BITS:0]   dx, dy;
  logic        [COORD_BITS:0]   dx_neg, dy_neg;
  logic        [COORD_BITS-1:0] adx, ady;
  logic signed [1:0]            ix, iy;
  logic                         x_fast;

  always_comb begin
    dx     = $signed({end_x_i[COORD_BITS-1], end_x_i})
           - $signed({start_x_i[COORD_BITS-1], start_x_i});
    dy     = $signed({end_y_i[COORD_BITS-1], end_y_i})
           - $signed({start_y_i[COORD_BITS-1], start_y_i});
    dx_neg = -dx;
    dy_neg = -dy;
    adx    = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady    = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    ix     = dx[COORD_BITS] ? 2'sb11 : ((dx != '0) ? 2'sb01 : 2'sb00);
    iy     = dy[COORD_BITS] ? 2'sb11 : ((dy != '0) ? 2'sb01 : 2'sb00);
    // y is the fast axis on a tie
    x_fast = (adx > ady);

    steps_o.diag_x = ix;
    steps_o.diag_y = iy;
    if (x_fast) begin
      steps_o.par_x = ix;
      steps_o.par_y = 2'sb00;
      fast_len_o    = adx;
      slow_len_o    = ady;
    end else begin
      steps_o.par_x = 2'sb00;
      steps_o.par_y = iy;
      fast_len_o    = ady;
      slow_len_o    = adx;
    end
    err_init_o = $signed({2'b00, fast_len_o[COORD_BITS-1:1]});
  end

endmodule

// ===== hw/rtl/lr_stepper.sv =====
// One Bresenham step: error update, step choice, position and count update.
// Depends on lr_pkg (steps_t).
module lr_stepper #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] cur_x_i,
  input  logic signed [COORD_BITS-1:0] cur_y_i,
  input  logic signed [COORD_BITS:0]   err_i,
  input  logic        [COORD_BITS-1:0] fast_len_i,
  input  logic        [COORD_BITS-1:0] slow_len_i,
  input  logic        [COORD_BITS-1:0] pixels_left_i,
  input  lr_pkg::steps_t               steps_i,
  output logic signed [COORD_BITS-1:0] cur_x_o,
  output logic signed [COORD_BITS-1:0] cur_y_o,
  output logic signed [COORD_BITS:0]   err_o,
  output logic        [COORD_BITS-1:0] pixels_left_o,
  output logic                         done_o
);

  logic signed [COORD_BITS:0]   err_sub;
  logic                         diag;
  logic signed [1:0]            sx, sy;

  always_comb begin
    // error stays in [0, fast_len), so one sign bit of headroom suffices
    err_sub = err_i - $signed({1'b0, slow_len_i});
    diag    = err_sub[COORD_BITS];
    err_o   = diag ? (err_sub + $signed({1'b0, fast_len_i})) : err_sub;
    sx      = diag ? steps_i.diag_x : steps_i.par_x;
    sy      = diag ? steps_i.diag_y : steps_i.par_y;
    cur_x_o = cur_x_i + {{(COORD_BITS-2){sx[1]}}, sx};
    cur_y_o = cur_y_i + {{(COORD_BITS-2){sy[1]}}, sy};
    // an active line always has at least one pixel left
    pixels_left_o = pixels_left_i - COORD_BITS'(1);
    done_o        = (pixels_left_i == COORD_BITS'(1));
  end

endmodule

// ===== hw/rtl/line_rasterizer_unit.sv =====
// Top level of the Bresenham line rasterizer: input register, line state,
// result register. Depends on lr_pkg, lr_start and lr_stepper.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): one transaction per command.
//   A start command (command_i = 0) loads endpoints and color and yields
//   the start pixel; a step command (command_i = 1) yields the next pixel
//   of the active line, or nothing when no line is active.
//   Output channel (out_valid_o / out_stall_i): one pixel per transaction,
//   offset by the origin registers, last_pixel_o set on the end point.
//   Config port: cfg_we_i writes origin_x (index 0) or origin_y (index 1).
//   Order: a taken command waits in the input register; its result is
//   loaded into the result register once the output is not stalled.
//   Throughput: one command per cycle unless the output stalls; the step
//   datapath (one subtract, one conditional add, position increment) sets it.
//   Reset: no line active, pipeline empty, origins at 100 / 160.
//   Stall: while out_stall_i holds a pending pixel, the block still takes
//   one command into its input register, then raises in_stall_o.
module line_rasterizer_unit #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = lr_pkg::COLOR_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic        [COLOR_BITS-1:0] color_i,
  // pixel channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS:0]   pixel_x_o,
  output logic signed [COORD_BITS:0]   pixel_y_o,
  output logic        [COLOR_BITS-1:0] pixel_color_o,
  output logic                         last_pixel_o,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic        [COORD_BITS-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------------
  logic advance;   // compute stage may move into the result register
  logic accept;    // input transaction taken this cycle

  // input register
  logic                         s1_valid_q;
  lr_pkg::cmd_e                 s1_cmd_q;
  logic signed [COORD_BITS-1:0] s1_sx_q, s1_sy_q, s1_ex_q, s1_ey_q;
  logic        [COLOR_BITS-1:0] s1_color_q;

  // line state
  logic                         active_q, active_d;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS:0]   err_q, err_d;
  logic        [COORD_BITS-1:0] fast_q, fast_d, slow_q, slow_d;
  logic        [COORD_BITS-1:0] left_q, left_d;
  lr_pkg::steps_t               steps_q, steps_d;
  logic        [COLOR_BITS-1:0] color_q, color_d;

  // origin registers
  logic signed [COORD_BITS-1:0] origin_x_q, origin_y_q;

  // result register
  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_BITS:0]   pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic        [COLOR_BITS-1:0] pix_color_q, pix_color_d;
  logic                         last_q, last_d;

  // setup and step datapaths
  logic        [COORD_BITS-1:0] st_fast, st_slow;
  logic signed [COORD_BITS:0]   st_err;
  lr_pkg::steps_t               st_steps;
  logic signed [COORD_BITS-1:0] sp_x, sp_y;
  logic signed [COORD_BITS:0]   sp_err;
  logic        [COORD_BITS-1:0] sp_left;
  logic                         sp_done;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  lr_start #(
    .COORD_BITS (COORD_BITS)
  ) u_start (
    .start_x_i  (s1_sx_q),
    .start_y_i  (s1_sy_q),
    .end_x_i    (s1_ex_q),
    .end_y_i    (s1_ey_q),
    .fast_len_o (st_fast),
    .slow_len_o (st_slow),
    .err_init_o (st_err),
    .steps_o    (st_steps)
  );

  lr_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .cur_x_i       (cur_x_q),
    .cur_y_i       (cur_y_q),
    .err_i         (err_q),
    .fast_len_i    (fast_q),
    .slow_len_i    (slow_q),
    .pixels_left_i (left_q),
    .steps_i       (steps_q),
    .cur_x_o       (sp_x),
    .cur_y_o       (sp_y),
    .err_o         (sp_err),
    .pixels_left_o (sp_left),
    .done_o        (sp_done)
  );

  // ---------------------------------------------------------------------
  // Compute stage: next line state and the pixel to present
  // ---------------------------------------------------------------------
  always_comb begin
    active_d    = active_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    err_d       = err_q;
    fast_d      = fast_q;
    slow_d      = slow_q;
    left_d      = left_q;
    steps_d     = steps_q;
    color_d     = color_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;

    if (advance) begin
      out_valid_d = 1'b0;
      if (s1_valid_q) begin
        unique case (s1_cmd_q)
          lr_pkg::CMD_START: begin
            // a start drops any line in progress
            cur_x_d     = s1_sx_q;
            cur_y_d     = s1_sy_q;
            err_d       = st_err;
            fast_d      = st_fast;
            slow_d      = st_slow;
            left_d      = st_fast;
            steps_d     = st_steps;
            color_d     = s1_color_q;
            active_d    = (st_fast != '0);
            out_valid_d = 1'b1;
            last_d      = (st_fast == '0);
          end
          lr_pkg::CMD_STEP: begin
            if (active_q) begin
              cur_x_d     = sp_x;
              cur_y_d     = sp_y;
              err_d       = sp_err;
              left_d      = sp_left;
              active_d    = !sp_done;
              out_valid_d = 1'b1;
              last_d      = sp_done;
            end
          end
          default: ;
        endcase
      end
    end

    pix_x_d     = $signed({cur_x_d[COORD_BITS-1], cur_x_d})
                + $signed({origin_x_q[COORD_BITS-1], origin_x_q});
    pix_y_d     = $signed({cur_y_d[COORD_BITS-1], cur_y_d})
                + $signed({origin_y_q[COORD_BITS-1], origin_y_q});
    pix_color_d = color_d;
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      origin_x_q  <= COORD_BITS'(lr_pkg::ORIGIN_X_RST);
      origin_y_q  <= COORD_BITS'(lr_pkg::ORIGIN_Y_RST);
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (lr_pkg::cfg_idx_e'(cfg_index_i))
          lr_pkg::CFG_ORIGIN_X: origin_x_q <= $signed(cfg_data_i);
          lr_pkg::CFG_ORIGIN_Y: origin_y_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= lr_pkg::cmd_e'(command_i);
      s1_sx_q    <= start_x_i;
      s1_sy_q    <= start_y_i;
      s1_ex_q    <= end_x_i;
      s1_ey_q    <= end_y_i;
      s1_color_q <= color_i;
    end
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    err_q   <= err_d;
    fast_q  <= fast_d;
    slow_q  <= slow_d;
    left_q  <= left_d;
    steps_q <= steps_d;
    color_q <= color_d;
    if (out_valid_d && advance) begin
      pix_x_q     <= pix_x_d;
      pix_y_q     <= pix_y_d;
      pix_color_q <= pix_color_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_color_o = pix_color_q;
  assign last_pixel_o  = last_q;

endmodule
